// ----- rtl/fssd_pkg.sv -----
// Shared widths, register indexes, reset values and types of the SSD best-match search.
package fssd_pkg;

  localparam int unsigned PixW   = 8;
  localparam int unsigned SqW    = 2 * PixW;
  localparam int unsigned SumW   = 40;
  localparam int unsigned LimitW = 16;
  localparam int unsigned BaseW  = 24;
  localparam int unsigned IndexW = 25;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = SumW;

  localparam logic [CfgIdxW-1:0] CFG_FRAME_LIMIT = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_INIT_BEST   = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_BASE_INDEX  = 2'd2;

  localparam logic [LimitW-1:0] FRAME_LIMIT_RST = 16'd250;
  localparam logic [SumW-1:0]   INIT_BEST_RST   = 40'd40000000;
  localparam logic [BaseW-1:0]  BASE_INDEX_RST  = 24'd0;

  typedef struct packed {
    logic [SumW-1:0]   running_sum;
    logic [SumW-1:0]   best_so_far;
    logic [LimitW-1:0] best_offset;
    logic [LimitW-1:0] frame_offset;
    logic              done;
    logic              exact;
  } fssd_next_t;

endpackage

// ----- rtl/fssd_score.sv -----
// Squared-difference accumulate and end-of-frame best-match decision for one staged beat.
module fssd_score import fssd_pkg::*; (
  input  logic [PixW-1:0]   ref_pixel_i,
  input  logic [PixW-1:0]   cand_pixel_i,
  input  logic              frame_end_i,
  input  logic              size_mismatch_i,
  input  logic [LimitW-1:0] frame_limit_i,
  input  logic [SumW-1:0]   running_sum_i,
  input  logic [SumW-1:0]   best_so_far_i,
  input  logic [LimitW-1:0] best_offset_i,
  input  logic [LimitW-1:0] frame_offset_i,
  output fssd_next_t        next_o
);

  logic [PixW-1:0]   diff;
  logic [SqW-1:0]    sq;
  logic [SumW:0]     sum_ext;
  logic [SumW-1:0]   sum_sat;
  logic [SumW-1:0]   total;
  logic [LimitW-1:0] offset_inc;

  always_comb begin
    diff       = (cand_pixel_i >= ref_pixel_i) ? (cand_pixel_i - ref_pixel_i)
                                                : (ref_pixel_i - cand_pixel_i);
    sq         = {{PixW{1'b0}}, diff} * {{PixW{1'b0}}, diff};
    sum_ext    = {1'b0, running_sum_i} + {{(SumW + 1 - SqW){1'b0}}, sq};
    sum_sat    = sum_ext[SumW] ? {SumW{1'b1}} : sum_ext[SumW-1:0];
    total      = size_mismatch_i ? running_sum_i : sum_sat;
    offset_inc = frame_offset_i + {{(LimitW - 1){1'b0}}, 1'b1};

    next_o.running_sum  = total;
    next_o.best_so_far  = best_so_far_i;
    next_o.best_offset  = best_offset_i;
    next_o.frame_offset = frame_offset_i;
    next_o.done         = 1'b0;
    next_o.exact        = 1'b0;

    if (frame_end_i) begin
      next_o.running_sum = '0;
      if (!size_mismatch_i) begin
        if (total == '0) begin
          next_o.best_offset = frame_offset_i;
          next_o.best_so_far = '0;
          next_o.exact       = 1'b1;
          next_o.done        = 1'b1;
        end else if (total < best_so_far_i) begin
          next_o.best_offset = frame_offset_i;
          next_o.best_so_far = total;
        end
      end
      if (!next_o.exact) begin
        next_o.frame_offset = offset_inc;
        if ((offset_inc == '0) || (offset_inc >= frame_limit_i)) begin
          next_o.done = 1'b1;
        end
      end
    end
  end

endmodule

// ----- rtl/frame_ssd_best_match_search.sv -----
// Top level of the SSD best-match frame search: input stage, search state and result register.
//
// Pixel-pair beats enter on the input channel (in_valid_i / in_stall_o) in frame order,
// with frame_end_i on the last byte of each candidate frame. Each beat is captured in an
// input register and scored in the next cycle: unless size_mismatch_i is set, its squared
// difference joins a saturating 40-bit sum and a frame end compares the sum with the best so far.
// When the search ends (exact match or frame limit reached) one result beat is loaded
// into the output register and presented on out_valid_o / out_stall_i; the search state
// then rearms for the next search.
// A final beat passes through the input register and then the output register. One beat is
// taken every cycle unless in_stall_o is high; the scoring stage, a single 8x8 square and 40-bit
// add and compare, sets that rate. While a result waits under out_stall_i, non-final beats keep
// flowing; a beat that would produce a second result holds in the input register and raises
// in_stall_o until the output register is taken. Configuration writes (cfg_we_i, cfg_idx_i,
// cfg_wdata_i) take effect at once and must be made by the user while the block is idle;
// the block does not enforce this. Reset loads the register defaults and clears the valid flags.
module frame_ssd_best_match_search import fssd_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [PixW-1:0]     ref_pixel_i,
  input  logic [PixW-1:0]     cand_pixel_i,
  input  logic                frame_end_i,
  input  logic                size_mismatch_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [IndexW-1:0]   found_index_o,
  output logic [SumW-1:0]     best_sum_o,
  output logic                exact_match_o
);

  logic [LimitW-1:0] frame_limit_q;
  logic [SumW-1:0]   init_best_q;
  logic [BaseW-1:0]  base_index_q;

  logic [SumW-1:0]   running_sum_q;
  logic [SumW-1:0]   best_so_far_q;
  logic [LimitW-1:0] best_offset_q;
  logic [LimitW-1:0] frame_offset_q;

  logic              stg_valid_q;
  logic [PixW-1:0]   stg_ref_q;
  logic [PixW-1:0]   stg_cand_q;
  logic              stg_end_q;
  logic              stg_skip_q;

  logic              out_valid_q;
  logic [IndexW-1:0] found_index_q;
  logic [SumW-1:0]   best_sum_q;
  logic              exact_q;

  fssd_next_t        nx;
  logic              advance;
  logic              in_ready;
  logic [IndexW-1:0] found_index_d;

  fssd_score u_score (
    .ref_pixel_i     (stg_ref_q),
    .cand_pixel_i    (stg_cand_q),
    .frame_end_i     (stg_end_q),
    .size_mismatch_i (stg_skip_q),
    .frame_limit_i   (frame_limit_q),
    .running_sum_i   (running_sum_q),
    .best_so_far_i   (best_so_far_q),
    .best_offset_i   (best_offset_q),
    .frame_offset_i  (frame_offset_q),
    .next_o          (nx)
  );

  assign advance       = stg_valid_q && (!nx.done || !out_valid_q || !out_stall_i);
  assign in_ready      = !stg_valid_q || advance;
  assign in_stall_o    = !in_ready;
  assign found_index_d = {1'b0, base_index_q} + {{(IndexW - LimitW){1'b0}}, nx.best_offset};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stg_valid_q <= 1'b0;
    end else if (in_ready) begin
      stg_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready && in_valid_i) begin
      stg_ref_q  <= ref_pixel_i;
      stg_cand_q <= cand_pixel_i;
      stg_end_q  <= frame_end_i;
      stg_skip_q <= size_mismatch_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_limit_q  <= FRAME_LIMIT_RST;
      init_best_q    <= INIT_BEST_RST;
      base_index_q   <= BASE_INDEX_RST;
      running_sum_q  <= '0;
      best_so_far_q  <= INIT_BEST_RST;
      best_offset_q  <= '0;
      frame_offset_q <= '0;
    end else begin
      if (advance) begin
        if (nx.done) begin
          running_sum_q  <= '0;
          best_so_far_q  <= init_best_q;
          best_offset_q  <= '0;
          frame_offset_q <= '0;
        end else begin
          running_sum_q  <= nx.running_sum;
          best_so_far_q  <= nx.best_so_far;
          best_offset_q  <= nx.best_offset;
          frame_offset_q <= nx.frame_offset;
        end
      end
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_FRAME_LIMIT: begin
            frame_limit_q <= cfg_wdata_i[LimitW-1:0];
          end
          CFG_INIT_BEST: begin
            init_best_q <= cfg_wdata_i[SumW-1:0];
            if (frame_offset_q == '0) begin
              best_so_far_q <= cfg_wdata_i[SumW-1:0];
            end
          end
          CFG_BASE_INDEX: begin
            base_index_q <= cfg_wdata_i[BaseW-1:0];
          end
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance && nx.done) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && nx.done) begin
      found_index_q <= found_index_d;
      best_sum_q    <= nx.best_so_far;
      exact_q       <= nx.exact;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign found_index_o = found_index_q;
  assign best_sum_o    = best_sum_q;
  assign exact_match_o = exact_q;

endmodule

// ----- dv/fssd_search_monitor.sv -----
// Watches the channels of the SSD best-match search, predicts each result and counts mismatches.
module fssd_search_monitor import fssd_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  input  logic                in_valid_i,
  input  logic                in_stall_i,
  input  logic [PixW-1:0]     ref_pixel_i,
  input  logic [PixW-1:0]     cand_pixel_i,
  input  logic                frame_end_i,
  input  logic                size_mismatch_i,
  input  logic                out_valid_i,
  input  logic                out_stall_i,
  input  logic [IndexW-1:0]   found_index_i,
  input  logic [SumW-1:0]     best_sum_i,
  input  logic                exact_match_i,
  output int unsigned         fail_count_o,
  output int unsigned         pending_o
);

  typedef struct packed {
    logic [IndexW-1:0] index;
    logic [SumW-1:0]   sum;
    logic              exact;
  } search_result_t;

  logic [LimitW-1:0] frame_limit;
  logic [SumW-1:0]   init_best;
  logic [BaseW-1:0]  base_index;
  logic [SumW-1:0]   acc_sum;
  logic [SumW-1:0]   best_sum;
  logic [LimitW-1:0] best_off;
  logic [LimitW-1:0] frame_off;

  search_result_t search_results_due[$];
  search_result_t want;
  int unsigned    errors;

  task automatic restart_search();
    acc_sum   = '0;
    best_sum  = init_best;
    best_off  = '0;
    frame_off = '0;
  endtask

  task automatic apply_write(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    case (idx)
      CFG_FRAME_LIMIT: frame_limit = data[LimitW-1:0];
      CFG_INIT_BEST: begin
        init_best = data[SumW-1:0];
        if (frame_off == '0) best_sum = init_best;
      end
      CFG_BASE_INDEX: base_index = data[BaseW-1:0];
      default: ;
    endcase
  endtask

  task automatic score_beat(input logic [PixW-1:0] r, input logic [PixW-1:0] c,
                            input logic fe, input logic sm);
    logic [PixW-1:0] diff;
    logic [SqW-1:0]  sq;
    logic [SumW:0]   wide;
    logic [SumW-1:0] total;
    logic            finished;
    logic            hit_zero;
    search_result_t  res;
    diff     = (c >= r) ? c - r : r - c;
    sq       = SqW'(diff) * SqW'(diff);
    finished = 1'b0;
    hit_zero = 1'b0;
    if (!sm) begin
      wide    = {1'b0, acc_sum} + (SumW+1)'(sq);
      acc_sum = wide[SumW] ? '1 : wide[SumW-1:0];
    end
    if (!fe) return;
    total   = acc_sum;
    acc_sum = '0;
    if (!sm) begin
      if (total == '0) begin
        best_off = frame_off;
        best_sum = '0;
        hit_zero = 1'b1;
        finished = 1'b1;
      end else if (total < best_sum) begin
        best_sum = total;
        best_off = frame_off;
      end
    end
    if (!finished) begin
      frame_off = frame_off + 16'd1;
      if (frame_off == '0 || frame_off >= frame_limit) finished = 1'b1;
    end
    if (finished) begin
      res.index = IndexW'(base_index) + IndexW'(best_off);
      res.sum   = best_sum;
      res.exact = hit_zero;
      search_results_due.push_back(res);
      restart_search();
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_limit = FRAME_LIMIT_RST;
      init_best   = INIT_BEST_RST;
      base_index  = BASE_INDEX_RST;
      restart_search();
      search_results_due.delete();
      errors = 0;
    end else begin
      if (cfg_we_i) apply_write(cfg_idx_i, cfg_wdata_i);
      if (out_valid_i && !out_stall_i) begin
        if (search_results_due.size() == 0) begin
          if (errors < 10) begin
            $display("%0t: result beat with none due: index %0d sum %0d exact %0b",
                     $realtime, found_index_i, best_sum_i, exact_match_i);
          end
          errors++;
        end else begin
          want = search_results_due.pop_front();
          if (found_index_i !== want.index || best_sum_i !== want.sum ||
              exact_match_i !== want.exact) begin
            if (errors < 10) begin
              $display("%0t: index exp %0d got %0d, sum exp %0d got %0d, exact exp %0b got %0b",
                       $realtime, want.index, found_index_i, want.sum, best_sum_i,
                       want.exact, exact_match_i);
            end
            errors++;
          end
        end
      end
      if (in_valid_i && !in_stall_i) begin
        score_beat(ref_pixel_i, cand_pixel_i, frame_end_i, size_mismatch_i);
      end
    end
    fail_count_o <= errors;
    pending_o    <= search_results_due.size();
  end

endmodule

// ----- dv/frame_ssd_best_match_search_tb.sv -----
// Testbench top of the SSD best-match search: clock, reset, stimulus, receiver and verdict.
module frame_ssd_best_match_search_tb;
  import fssd_pkg::*;

  localparam int unsigned IdlePct     = 34;
  localparam int unsigned HoldCycles  = 300;
  localparam int unsigned DrainCycles = 6;
  localparam int unsigned RandomBeats = 550;
  localparam int unsigned CycleLimit  = 300000;
  localparam logic [CfgIdxW-1:0] CFG_UNUSED = 2'd3;

  typedef enum int unsigned {FRAME_CLOSE, FRAME_WILD, FRAME_EXACT, FRAME_SKIP} frame_kind_e;

  logic                clk_i           = 1'b0;
  logic                rst_ni          = 1'b0;
  logic                cfg_we_i        = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i       = '0;
  logic [CfgDataW-1:0] cfg_wdata_i     = '0;
  logic                in_valid_i      = 1'b0;
  logic [PixW-1:0]     ref_pixel_i     = '0;
  logic [PixW-1:0]     cand_pixel_i    = '0;
  logic                frame_end_i     = 1'b0;
  logic                size_mismatch_i = 1'b0;
  logic                out_stall_i     = 1'b0;
  logic                in_stall_o;
  logic                out_valid_o;
  logic [IndexW-1:0]   found_index_o;
  logic [SumW-1:0]     best_sum_o;
  logic                exact_match_o;

  int unsigned fail_count;
  int unsigned pending;
  int unsigned in_idle_pct  = IdlePct;
  int unsigned out_idle_pct = IdlePct;
  int unsigned hold_asked   = 0;
  int unsigned hold_served  = 0;
  int unsigned beats_sent   = 0;
  int unsigned cycle_count  = 0;
  int unsigned phase;
  int unsigned random_start;

  frame_ssd_best_match_search u_top (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_wdata_i,
    .in_valid_i, .in_stall_o, .ref_pixel_i, .cand_pixel_i, .frame_end_i, .size_mismatch_i,
    .out_valid_o, .out_stall_i, .found_index_o, .best_sum_o, .exact_match_o
  );

  fssd_search_monitor u_monitor (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_wdata_i,
    .in_valid_i, .in_stall_i(in_stall_o), .ref_pixel_i, .cand_pixel_i,
    .frame_end_i, .size_mismatch_i,
    .out_valid_i(out_valid_o), .out_stall_i, .found_index_i(found_index_o),
    .best_sum_i(best_sum_o), .exact_match_i(exact_match_o),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  always #10 clk_i = ~clk_i;

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // A requested hold keeps the result side stalled long enough to back up the input.
  initial begin
    forever begin
      @(posedge clk_i);
      if (hold_served != hold_asked) begin
        out_stall_i <= 1'b1;
        repeat (HoldCycles - 1) @(posedge clk_i);
        hold_served++;
      end else begin
        out_stall_i <= ($urandom_range(99) < out_idle_pct);
      end
    end
  end

  task automatic send_beat(input logic [PixW-1:0] r, input logic [PixW-1:0] c,
                           input logic fe, input logic sm);
    while (in_idle_pct != 0 && $urandom_range(99) < in_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i      <= 1'b1;
    ref_pixel_i     <= r;
    cand_pixel_i    <= c;
    frame_end_i     <= fe;
    size_mismatch_i <= sm;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    beats_sent++;
  endtask

  task automatic drain_results();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic send_frame(input frame_kind_e kind, input int unsigned len);
    logic [PixW-1:0] r;
    logic [PixW-1:0] c;
    logic            last;
    logic            sm;
    for (int unsigned i = 0; i < len; i++) begin
      r    = PixW'($urandom_range(255));
      last = (i == len - 1);
      case (kind)
        FRAME_EXACT: c = r;
        FRAME_CLOSE: c = r + PixW'($urandom_range(16)) - PixW'(8);
        default:     c = PixW'($urandom_range(255));
      endcase
      if (kind == FRAME_SKIP) sm = last | 1'($urandom_range(1));
      else                    sm = ($urandom_range(99) < 3);
      send_beat(r, c, last, sm);
    end
  endtask

  function automatic frame_kind_e pick_kind();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 15) return FRAME_EXACT;
    if (roll < 25) return FRAME_SKIP;
    if (roll < 70) return FRAME_CLOSE;
    return FRAME_WILD;
  endfunction

  function automatic logic [CfgDataW-1:0] pick_limit();
    case ($urandom_range(19))
      0:       return '0;
      1:       return CfgDataW'(16'hFFFF);
      2, 3:    return CfgDataW'($urandom_range(40, 1));
      4:       return {24'($urandom_range(24'hFFFFFF)), 16'($urandom_range(8, 1))};
      default: return CfgDataW'($urandom_range(8, 1));
    endcase
  endfunction

  function automatic logic [CfgDataW-1:0] pick_threshold();
    case ($urandom_range(9))
      0:       return '0;
      1:       return '1;
      2:       return {8'($urandom_range(255)), 32'($urandom())};
      3, 4:    return CfgDataW'($urandom_range(200000));
      default: return CfgDataW'($urandom_range(3000));
    endcase
  endfunction

  function automatic logic [CfgDataW-1:0] pick_base();
    case ($urandom_range(7))
      0:       return '0;
      1:       return CfgDataW'(24'hFFFFFF);
      2:       return {16'($urandom_range(16'hFFFF)), 24'($urandom_range(24'hFFFFFF))};
      default: return CfgDataW'($urandom_range(24'hFFFFFF));
    endcase
  endfunction

  task automatic run_phase(input int unsigned p);
    int unsigned frames;
    int unsigned len;
    drain_results();
    in_idle_pct  = IdlePct;
    out_idle_pct = IdlePct;
    frames       = $urandom_range(20, 4);
    if ($urandom_range(99) < 60) write_reg(CFG_FRAME_LIMIT, pick_limit());
    if ($urandom_range(99) < 60) write_reg(CFG_INIT_BEST, pick_threshold());
    if ($urandom_range(99) < 60) write_reg(CFG_BASE_INDEX, pick_base());
    if ($urandom_range(99) < 5)  write_reg(CFG_UNUSED, pick_threshold());
    if (p == 2) begin
      in_idle_pct  = 0;
      out_idle_pct = 0;
      frames       = 60;
    end
    if (p == 4) begin
      write_reg(CFG_FRAME_LIMIT, CfgDataW'(1));
      in_idle_pct = 0;
      hold_asked++;
      frames = 30;
    end
    repeat (frames) begin
      len = ($urandom_range(9) == 0) ? $urandom_range(40, 7) : $urandom_range(6, 1);
      send_frame(pick_kind(), len);
    end
  endtask

  initial begin
    wait (rst_ni);
    @(posedge clk_i);

    write_reg(CFG_FRAME_LIMIT, CfgDataW'(1));
    write_reg(CFG_INIT_BEST, '1);
    write_reg(CFG_BASE_INDEX, CfgDataW'(24'hFFFFFF));
    send_beat(8'd0, 8'd255, 1'b1, 1'b0);
    send_beat(8'd255, 8'd0, 1'b0, 1'b0);
    send_beat(8'd255, 8'd0, 1'b1, 1'b0);
    send_beat(8'd128, 8'd128, 1'b1, 1'b0);
    send_beat(8'd1, 8'd2, 1'b0, 1'b1);
    send_beat(8'd3, 8'd200, 1'b1, 1'b1);

    // Zero limit and a zero threshold.
    drain_results();
    write_reg(CFG_FRAME_LIMIT, '0);
    write_reg(CFG_INIT_BEST, '0);
    write_reg(CFG_BASE_INDEX, '0);
    send_beat(8'd10, 8'd20, 1'b1, 1'b0);

    // A sum equal to the threshold does not replace it.
    drain_results();
    write_reg(CFG_FRAME_LIMIT, CfgDataW'(2));
    write_reg(CFG_INIT_BEST, CfgDataW'(1));
    send_beat(8'd5, 8'd6, 1'b1, 1'b0);
    send_beat(8'd7, 8'd7, 1'b1, 1'b0);

    drain_results();
    write_reg(CFG_FRAME_LIMIT, CfgDataW'(16'hFFFF));
    write_reg(CFG_UNUSED, '1);
    send_beat(8'd0, 8'd0, 1'b0, 1'b0);
    send_beat(8'd255, 8'd255, 1'b1, 1'b0);

    // Limit lowered and threshold rewritten in the middle of a search.
    send_beat(8'hAA, 8'h55, 1'b1, 1'b0);
    send_beat(8'h55, 8'hAA, 1'b1, 1'b0);
    drain_results();
    write_reg(CFG_INIT_BEST, CfgDataW'(50));
    write_reg(CFG_FRAME_LIMIT, CfgDataW'(1));
    send_beat(8'd40, 8'd44, 1'b1, 1'b0);
    send_beat(8'd9, 8'd12, 1'b1, 1'b0);

    phase        = 0;
    random_start = beats_sent;
    while (beats_sent - random_start < RandomBeats || phase < 6) begin
      run_phase(phase);
      phase++;
    end
    drain_results();

    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
